>>> hw/rtl/npsi_pkg.sv
// shared types and constants for the nearest point search block
// no dependencies; imported by npsi_ctrl, npsi_dp and the top level
package npsi_pkg;

	// field widths
	localparam int SLOT_W  = 4;
	localparam int COORD_W = 14;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int SQ_W    = 28;
	localparam int SUM_W   = SQ_W + 1;
	localparam int DIST_W  = 15;

	// square root unit: one result bit per step, 16 result bits
	localparam int             ROOT_W        = 32;
	localparam int             ROOT_TOP_SHIFT = 15;
	localparam logic [3:0]     ROOT_LAST     = 4'(ROOT_TOP_SHIFT);
	localparam logic [ROOT_W-1:0] ROOT_ONE_INIT =
		ROOT_W'(64'h8000 * 64'h8000);

	// item kinds
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// controller to datapath commands
	typedef struct packed {
		logic take_item;
		logic write_entry;
		logic fetch;
		logic diff;
		logic square_x;
		logic square_y;
		logic root_init;
		logic root_step;
		logic compare;
		logic out_load;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic ent_valid;
	} stat_t;

endpackage

>>> hw/rtl/npsi_ctrl.sv
// controller state machine for the nearest point search block
// depends on npsi_pkg; drives npsi_dp through cmd_t and owns both handshakes
module npsi_ctrl import npsi_pkg::*; #(
	parameter int STORE = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 in_opcode,
	output logic                 out_valid,
	input  logic                 out_ready,
	output cmd_t                 cmd,
	input  stat_t                stat,
	output logic [((STORE > 1) ? $clog2(STORE) : 1)-1:0] scan_idx
);

	localparam int IDX_W = (STORE > 1) ? $clog2(STORE) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(STORE - 1);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_FETCH = 9'b000000010,
		ST_DIFF  = 9'b000000100,
		ST_SQX   = 9'b000001000,
		ST_SQY   = 9'b000010000,
		ST_INIT  = 9'b000100000,
		ST_ROOT  = 9'b001000000,
		ST_CMP   = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	state_t           state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [3:0]       step_q, step_d;
	logic             out_valid_q, out_valid_d;
	logic             accept;
	logic             out_free;

	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign scan_idx  = idx_q;

	// next state and commands
	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		step_d      = step_q;
		out_valid_d = out_valid_q && !out_ready;
		cmd         = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.take_item = 1'b1;
					idx_d         = '0;
					if (in_opcode == OP_WRITE) begin
						cmd.write_entry = 1'b1;
						state_d         = ST_DONE;
					end else begin
						state_d = ST_FETCH;
					end
				end
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				if (stat.ent_valid) begin
					state_d = ST_SQX;
				end else if (idx_q == IDX_LAST) begin
					state_d = ST_DONE;
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = ST_FETCH;
				end
			end
			ST_SQX: begin
				cmd.square_x = 1'b1;
				state_d      = ST_SQY;
			end
			ST_SQY: begin
				cmd.square_y = 1'b1;
				state_d      = ST_INIT;
			end
			ST_INIT: begin
				cmd.root_init = 1'b1;
				step_d        = '0;
				state_d       = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (step_q == ROOT_LAST) begin
					state_d = ST_CMP;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_CMP: begin
				cmd.compare = 1'b1;
				if (idx_q == IDX_LAST) begin
					state_d = ST_DONE;
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = ST_FETCH;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			idx_q       <= idx_d;
			step_q      <= step_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule

>>> hw/rtl/npsi_dp.sv
// datapath for the nearest point search block: entry tables, distance,
// square root, best tracking and result register; depends on npsi_pkg
module npsi_dp import npsi_pkg::*; #(
	parameter int STORE = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	output stat_t                     stat,
	input  logic [((STORE > 1) ? $clog2(STORE) : 1)-1:0] scan_idx,
	input  logic                      in_side,
	input  logic [SLOT_W-1:0]         in_slot,
	input  logic                      in_entry_valid,
	input  logic signed [COORD_W-1:0] in_x,
	input  logic signed [COORD_W-1:0] in_y,
	output logic                      out_found,
	output logic [SLOT_W-1:0]         out_slot,
	output logic [DIST_W-1:0]         out_dist
);

	localparam int IDX_W = (STORE > 1) ? $clog2(STORE) : 1;

	// entry tables, one row per side
	logic                      valid_q [2][STORE];
	logic signed [COORD_W-1:0] x_q     [2][STORE];
	logic signed [COORD_W-1:0] y_q     [2][STORE];

	logic                      side_q;
	logic signed [COORD_W-1:0] qx_q, qy_q;
	logic                      ent_valid_q;
	logic signed [COORD_W-1:0] ent_x_q, ent_y_q;
	logic signed [DIFF_W-1:0]  dx_q, dy_q;
	logic [SQ_W-1:0]           sqx_q, sqy_q;
	logic [ROOT_W-1:0]         op_q, res_q, one_q;
	logic                      have_q;
	logic [IDX_W-1:0]          best_idx_q;
	logic [DIST_W-1:0]         best_dist_q;
	logic                      slot_ok;
	logic [IDX_W-1:0]          wr_idx;
	logic signed [DIFF_W-1:0]  mul_in;
	logic signed [2*DIFF_W-1:0] prod;
	logic [SUM_W-1:0]          sum;
	logic [ROOT_W-1:0]         trial;

	assign slot_ok = (int'(in_slot) < STORE);
	assign wr_idx  = in_slot[IDX_W-1:0];
	assign stat.ent_valid = ent_valid_q;

	// valid marks, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < 2; s++) begin
				for (int i = 0; i < STORE; i++) begin
					valid_q[s][i] <= 1'b0;
				end
			end
		end else if (cmd.write_entry && slot_ok) begin
			valid_q[in_side][wr_idx] <= in_entry_valid;
		end
	end

	// coordinates, only used behind a set valid mark
	always_ff @(posedge clk) begin
		if (cmd.write_entry && slot_ok) begin
			x_q[in_side][wr_idx] <= in_x;
			y_q[in_side][wr_idx] <= in_y;
		end
	end

	// query capture and entry fetch
	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			side_q <= in_side;
			qx_q   <= in_x;
			qy_q   <= in_y;
		end
		if (cmd.fetch) begin
			ent_valid_q <= valid_q[side_q][scan_idx];
			ent_x_q     <= x_q[side_q][scan_idx];
			ent_y_q     <= y_q[side_q][scan_idx];
		end
	end

	// differences and one shared multiplier for both squares
	assign mul_in = cmd.square_y ? dy_q : dx_q;
	assign prod   = mul_in * mul_in;
	assign sum    = SUM_W'(sqx_q) + SUM_W'(sqy_q);

	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			dx_q <= DIFF_W'(ent_x_q) - DIFF_W'(qx_q);
			dy_q <= DIFF_W'(ent_y_q) - DIFF_W'(qy_q);
		end
		if (cmd.square_x) begin
			sqx_q <= prod[SQ_W-1:0];
		end
		if (cmd.square_y) begin
			sqy_q <= prod[SQ_W-1:0];
		end
	end

	// restoring square root, one result bit per step
	assign trial = res_q + one_q;

	always_ff @(posedge clk) begin
		if (cmd.root_init) begin
			op_q  <= ROOT_W'(sum);
			res_q <= '0;
			one_q <= ROOT_ONE_INIT;
		end else if (cmd.root_step) begin
			if (op_q >= trial) begin
				op_q  <= op_q - trial;
				res_q <= (res_q >> 1) + one_q;
			end else begin
				res_q <= res_q >> 1;
			end
			one_q <= one_q >> 2;
		end
	end

	// best entry so far, first strictly lowest wins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (cmd.take_item) begin
			have_q <= 1'b0;
		end else if (cmd.compare) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.compare && (!have_q || (res_q < ROOT_W'(best_dist_q)))) begin
			best_idx_q  <= scan_idx;
			best_dist_q <= res_q[DIST_W-1:0];
		end
	end

	// result register, zeros when nothing was found or for writes
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_found <= have_q;
			out_slot  <= have_q ? SLOT_W'(best_idx_q) : '0;
			out_dist  <= have_q ? best_dist_q : '0;
		end
	end

endmodule

>>> hw/rtl/nearest_point_search_isqrt_unit.sv
// top level of the nearest point search block with integer square root
// depends on npsi_pkg, npsi_ctrl and npsi_dp
//
//  channel | direction | tdata                                  | tuser
//  s_*     | in        | slot, entry_valid, point_x, point_y    | opcode, side
//  m_*     | out       | nearest_slot, nearest_distance         | found
//
// a write goes from accept straight to the result stage. a query scans the
// N entries of one side (at most 16): fetch, difference, squares, the 16-step
// square root unit and the compare per valid entry; an invalid entry is dropped
// after its difference. one item is in work at a time; the result register lets
// the next item be accepted while a result waits. reset clears all valid marks.
module nearest_point_search_isqrt_unit import npsi_pkg::*; #(
	parameter int ENTRIES_PER_SIDE = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // slot[3:0], entry_valid[4], point_x[18:5],
	                              // point_y[32:19], zero fill
	input  logic [1:0]  s_tuser,  // opcode[0], side[1]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // nearest_slot[3:0], nearest_distance[18:4],
	                              // zero fill
	output logic        m_tuser   // found
);

	// slots above 15 can never be written, so only the low ones are stored
	localparam int STORE = (ENTRIES_PER_SIDE < 16) ? ENTRIES_PER_SIDE : 16;
	localparam int IDX_W = (STORE > 1) ? $clog2(STORE) : 1;

	cmd_t              cmd;
	stat_t             stat;
	logic [IDX_W-1:0]  scan_idx;
	logic              res_found;
	logic [SLOT_W-1:0] res_slot;
	logic [DIST_W-1:0] res_dist;

	npsi_ctrl #(
		.STORE (STORE)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_opcode (s_tuser[0]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.stat      (stat),
		.scan_idx  (scan_idx)
	);

	npsi_dp #(
		.STORE (STORE)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.scan_idx       (scan_idx),
		.in_side        (s_tuser[1]),
		.in_slot        (s_tdata[3:0]),
		.in_entry_valid (s_tdata[4]),
		.in_x           (s_tdata[18:5]),
		.in_y           (s_tdata[32:19]),
		.out_found      (res_found),
		.out_slot       (res_slot),
		.out_dist       (res_dist)
	);

	// result packing
	assign m_tdata = {5'b0, res_dist, res_slot};
	assign m_tuser = res_found;

endmodule

>>> tb/nearest_point_search_isqrt_unit_test.sv
// self-checking testbench for nearest_point_search_isqrt_unit: a predictor keeps its own copy of
// both point tables and the expected nearest-entry results; depends on npsi_pkg and the rtl
module nearest_point_search_isqrt_unit_test;
	import npsi_pkg::*;

	localparam int ENTRIES     = 16;
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int DRAIN_WAIT  = 400;
	localparam int PHASE_ITEMS = 405;

	// one result transaction as the block reports it
	typedef struct packed {
		logic        found;
		logic [3:0]  slot;
		logic [14:0] distance;
	} nearest_result_t;

	// predicts each result from its own copy of the tables and checks results in order
	class nearest_point_scoreboard;
		bit              tbl_valid [2][ENTRIES];
		int              tbl_x [2][ENTRIES];
		int              tbl_y [2][ENTRIES];
		nearest_result_t pending_nearest [$];
		int              errors;

		function new();
			errors = 0;
			foreach (tbl_valid[s, i]) begin
				tbl_valid[s][i] = 0;
				tbl_x[s][i] = 0;
				tbl_y[s][i] = 0;
			end
		endfunction

		// restoring square root, one result bit per step from bit 15 down
		function longint unsigned root_restoring(longint unsigned v);
			longint unsigned rem;
			longint unsigned root;
			longint unsigned trial;
			rem = v;
			root = 0;
			for (int sh = 15; sh >= 0; sh--) begin
				trial = ((root << 1) + (64'd1 << sh)) << sh;
				if (rem >= trial) begin
					root += (64'd1 << sh);
					rem -= trial;
				end
			end
			return root;
		endfunction

		// update the tables or scan one side, then queue the expected result
		function void apply_item(logic op, logic side, logic [3:0] slot, logic valid,
				logic signed [13:0] px, logic signed [13:0] py);
			nearest_result_t r;
			longint dx;
			longint dy;
			longint unsigned d;
			r = '0;
			if (op == OP_WRITE) begin
				if (slot < ENTRIES) begin
					tbl_valid[side][slot] = valid;
					tbl_x[side][slot] = px;
					tbl_y[side][slot] = py;
				end
			end else begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (tbl_valid[side][i]) begin
						dx = longint'(tbl_x[side][i]) - longint'(px);
						dy = longint'(tbl_y[side][i]) - longint'(py);
						d = root_restoring(longint'(dx * dx + dy * dy));
						if (!r.found || d < r.distance) begin
							r.found = 1'b1;
							r.slot = 4'(i);
							r.distance = 15'(d);
						end
					end
				end
			end
			pending_nearest.push_back(r);
		endfunction

		// compare one result transaction with the oldest expectation
		function void check_nearest(nearest_result_t got);
			nearest_result_t want;
			if (pending_nearest.size() == 0) begin
				$error("result with none expected: found %0d slot %0d distance %0d",
					got.found, got.slot, got.distance);
				errors++;
				return;
			end
			want = pending_nearest.pop_front();
			if (got.found !== want.found) begin
				$error("found mismatch: expected %0d, actual %0d", want.found, got.found);
				errors++;
			end
			if (got.slot !== want.slot) begin
				$error("nearest_slot mismatch: expected %0d, actual %0d", want.slot, got.slot);
				errors++;
			end
			if (got.distance !== want.distance) begin
				$error("nearest_distance mismatch: expected %0d, actual %0d",
					want.distance, got.distance);
				errors++;
			end
		endfunction

		function int outstanding();
			return pending_nearest.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;  // slot, entry_valid, point_x, point_y, zero fill
	logic [1:0]  s_tuser = '0;  // opcode, side
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;       // nearest_slot, nearest_distance, zero fill
	logic        m_tuser;       // found

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned cycle_count = 0;
	nearest_point_scoreboard board;

	nearest_point_search_isqrt_unit #(
		.ENTRIES_PER_SIDE(ENTRIES)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	// cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// result side: check accepted transactions, stall at random
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_nearest({m_tuser, m_tdata[3:0], m_tdata[18:4]});
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// drive one input transaction and note it once accepted
	task automatic send_item(logic op, logic side, logic [3:0] slot, logic valid,
			logic signed [13:0] px, logic signed [13:0] py);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, py, px, valid, slot};
		s_tuser <= {side, op};
		do @(posedge clk); while (!s_tready);
		board.apply_item(op, side, slot, valid, px, py);
	endtask

	// hold the input side idle until every expected result has come
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (board.outstanding() != 0) @(posedge clk);
	endtask

	// coordinates: mostly full range, some clustered near the origin, some extremes
	function automatic logic signed [13:0] pick_coord();
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(3))
					0: return -14'sd8192;
					1: return 14'sd8191;
					2: return 14'sd0;
					default: return -14'sd1;
				endcase
			end
			1, 2, 3: return 14'($urandom_range(40)) - 14'sd20;
			default: return 14'($urandom);
		endcase
	endfunction

	task automatic send_random();
		logic side;
		side = 1'($urandom);
		if ($urandom_range(149) == 0) begin
			// wipe a whole side so that sparse and empty tables get queried
			for (int i = 0; i < ENTRIES; i++)
				send_item(OP_WRITE, side, 4'(i), 1'b0, pick_coord(), pick_coord());
		end else if ($urandom_range(99) < 45) begin
			send_item(OP_WRITE, side, 4'($urandom), ($urandom_range(99) < 80),
				pick_coord(), pick_coord());
		end else begin
			send_item(OP_QUERY, side, 4'($urandom), 1'($urandom), pick_coord(), pick_coord());
		end
	endtask

	// stimulus and final verdict
	initial begin
		board = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty tables report nothing found
		send_item(OP_QUERY, 1'b0, 4'd0, 1'b0, 14'sd0, 14'sd0);
		send_item(OP_QUERY, 1'b1, 4'd15, 1'b1, 14'sd8191, -14'sd8192);
		// farthest possible distance across the coordinate range
		send_item(OP_WRITE, 1'b0, 4'd0, 1'b1, -14'sd8192, -14'sd8192);
		send_item(OP_QUERY, 1'b0, 4'd0, 1'b0, 14'sd8191, 14'sd8191);
		send_item(OP_WRITE, 1'b0, 4'd15, 1'b1, 14'sd8191, 14'sd8191);
		send_item(OP_QUERY, 1'b0, 4'd3, 1'b1, 14'sd8191, 14'sd8191);
		// invalid entry keeps its coordinates but is never reported
		send_item(OP_WRITE, 1'b1, 4'd3, 1'b0, 14'sd0, 14'sd0);
		send_item(OP_QUERY, 1'b1, 4'd3, 1'b1, 14'sd0, 14'sd0);
		// equal distances: lowest index wins
		send_item(OP_WRITE, 1'b1, 4'd9, 1'b1, -14'sd10, 14'sd0);
		send_item(OP_WRITE, 1'b1, 4'd5, 1'b1, 14'sd10, 14'sd0);
		send_item(OP_QUERY, 1'b1, 4'd0, 1'b0, 14'sd0, 14'sd0);
		send_item(OP_WRITE, 1'b1, 4'd2, 1'b1, 14'sd3, 14'sd4);
		send_item(OP_QUERY, 1'b1, 4'd15, 1'b1, 14'sd0, 14'sd0);
		// truncated root of a non-square sum
		send_item(OP_WRITE, 1'b0, 4'd7, 1'b1, 14'sd1, 14'sd1);
		send_item(OP_QUERY, 1'b0, 4'd0, 1'b0, 14'sd0, 14'sd0);
		send_item(OP_QUERY, 1'b0, 4'd0, 1'b0, -14'sd1, 14'sd2);
		// invalidate and move entries, opposite corners
		send_item(OP_WRITE, 1'b0, 4'd0, 1'b0, 14'sd8191, -14'sd8192);
		send_item(OP_WRITE, 1'b1, 4'd15, 1'b1, -14'sd8192, 14'sd8191);
		send_item(OP_QUERY, 1'b1, 4'd0, 1'b0, 14'sd8191, -14'sd8192);
		send_item(OP_QUERY, 1'b0, 4'd0, 1'b0, -14'sd8192, 14'sd8191);
		send_item(OP_WRITE, 1'b1, 4'd2, 1'b0, -14'sd1, -14'sd1);
		send_item(OP_QUERY, 1'b1, 4'd0, 1'b0, 14'sd4, 14'sd0);
		wait_drained();

		// random traffic under several idle and stall patterns
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
				default: begin send_idle_pct = 30; recv_stall_pct = 30; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_random();
			wait_drained();
		end

		s_tvalid <= 1'b0;
		while (board.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (board.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
